[src/mpwea_pkg.sv]
// mpwea_pkg: shared types, status codes and length tables for the packed word event assembler
// used by the front classifier, the command queue and the back end
package mpwea_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_START  = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_BROKEN     = 2'd2
	} evst_t;

	localparam logic [7:0] STATUS_MIN   = 8'h80;
	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam logic [7:0] STATUS_EOX   = 8'hF7;
	localparam logic [7:0] STATUS_RT    = 8'hF8;
	localparam logic [3:0] NIBBLE_SYS   = 4'hF;
	localparam logic [2:0] LEN_INVALID  = 3'd4;
	localparam logic [2:0] LEN_WORD     = 3'd4;

	localparam logic [1:0] HIGH_LEN [0:7] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1};
	localparam logic [1:0] LOW_LEN  [0:7] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};

	// classified request handed from the front to the back
	typedef struct packed {
		op_t             op;
		logic [9:0]      read_index;
		logic [3:0][7:0] msg;
		logic            sysex_start;
		logic            short_ok;
		logic [1:0]      short_len;
		logic            spawn_always;
		logic            spawn_if_held;
		logic            eox_found;
		logic [2:0]      sysex_len;
		evst_t           fresh_state;
		logic [2:0]      fresh_size;
	} cmd_t;

	function automatic logic [2:0] short_len(input logic [7:0] status);
		logic [2:0] len;
		if (status < STATUS_MIN) begin
			len = LEN_INVALID;
		end else if (status[7:4] != NIBBLE_SYS) begin
			len = {1'b0, HIGH_LEN[status[6:4]]};
		end else if (!status[3]) begin
			len = {1'b0, LOW_LEN[status[2:0]]};
		end else begin
			len = 3'd1;
		end
		return len;
	endfunction

endpackage

[src/mpwea_front.sv]
// mpwea_front: input handshake and classification of each request into a cmd_t
// depends on mpwea_pkg
module mpwea_front (
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [47:0]         s_axis_tdata,  // message[31:0], read_index[41:32], zero
	input  logic [1:0]          s_axis_tuser,  // operation[1:0]
	input  logic                q_full,
	output logic                q_push,
	output mpwea_pkg::cmd_t     q_cmd
);
	import mpwea_pkg::*;

	logic [7:0] status;
	logic [2:0] len;
	logic       eox_found;
	logic [2:0] sysex_len;

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;
	assign status        = s_axis_tdata[7:0];
	assign len           = short_len(status);

	// first eox lane, scanned from the top so the lowest match wins
	always_comb begin
		eox_found = 1'b0;
		sysex_len = LEN_WORD;
		for (int i = 3; i >= 0; i--) begin
			if (s_axis_tdata[8*i +: 8] == STATUS_EOX) begin
				eox_found = 1'b1;
				sysex_len = 3'(i + 1);
			end
		end
	end

	always_comb begin
		q_cmd               = '0;
		q_cmd.op            = op_t'(s_axis_tuser);
		q_cmd.read_index    = s_axis_tdata[41:32];
		q_cmd.msg           = s_axis_tdata[31:0];
		q_cmd.sysex_start   = (status == STATUS_SYSEX);
		q_cmd.short_ok      = (len != LEN_INVALID);
		q_cmd.short_len     = len[1:0];
		q_cmd.spawn_always  = (status >= STATUS_RT);
		q_cmd.spawn_if_held = (status >= STATUS_MIN) && (status != STATUS_EOX);
		q_cmd.eox_found     = eox_found;
		q_cmd.sysex_len     = sysex_len;
		if (status == STATUS_SYSEX) begin
			q_cmd.fresh_state = eox_found ? ST_COMPLETE : ST_INCOMPLETE;
			q_cmd.fresh_size  = sysex_len;
		end else if (len != LEN_INVALID) begin
			q_cmd.fresh_state = ST_COMPLETE;
			q_cmd.fresh_size  = len;
		end else begin
			q_cmd.fresh_state = ST_BROKEN;
			q_cmd.fresh_size  = 3'd0;
		end
	end

endmodule

[src/mpwea_queue.sv]
// mpwea_queue: two-entry queue of classified requests between front and back
// depends on mpwea_pkg
module mpwea_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mpwea_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output mpwea_pkg::cmd_t head
);
	import mpwea_pkg::*;

	cmd_t       entry_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[src/mpwea_back.sv]
// mpwea_back: event state, four-bank byte store and the registered result stage
// depends on mpwea_pkg; takes classified requests from mpwea_queue
module mpwea_back #(
	parameter int BUFFER_BYTES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  mpwea_pkg::cmd_t cmd,
	output logic            q_pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [31:0]     m_axis_tdata,  // event_state, event_size, spawned_state,
	                                        // spawned_size, read_byte, zero
	output logic [0:0]      m_axis_tuser   // spawned
);
	import mpwea_pkg::*;

	localparam int CW   = $clog2(BUFFER_BYTES + 1);
	localparam int D    = (BUFFER_BYTES + 3) / 4;
	localparam int RW   = $clog2(D);
	localparam int CMPW = (CW > 10) ? CW : 10;

	evst_t           st_q, st_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            hb_q, hb_d;
	logic            spawn;
	logic [2:0]      n_wr;
	logic [CW:0]     sum;
	logic [CW-1:0]   room;
	logic [CMPW-1:0] idx_ext;
	logic [RW-1:0]   rd_row;
	logic            rd_hit;

	logic            out_valid_q;
	evst_t           ev_state_q;
	logic [10:0]     ev_size_q;
	logic            spawned_q;
	evst_t           sp_state_q;
	logic [2:0]      sp_size_q;
	logic            hit_q;
	logic [1:0]      lane_q;
	logic [3:0][7:0] rd_row_q;
	logic [7:0]      read_byte;

	assign q_pop   = q_valid && (!out_valid_q || m_axis_tready);
	assign sum     = {1'b0, cnt_q} + (CW + 1)'(cmd.sysex_len);
	assign room    = CW'(BUFFER_BYTES) - cnt_q;
	assign idx_ext = CMPW'(cmd.read_index);
	assign rd_row  = idx_ext[2 +: RW];
	assign rd_hit  = (cmd.op == OP_READ) && (idx_ext < CMPW'(cnt_q));

	always_comb begin
		st_d  = st_q;
		cnt_d = cnt_q;
		hb_d  = hb_q;
		spawn = 1'b0;
		n_wr  = 3'd0;
		case (cmd.op)
			OP_APPEND: begin
				if (st_q != ST_INCOMPLETE) begin
					st_d = ST_BROKEN;
				end else if (!hb_q && !cmd.sysex_start) begin
					hb_d = 1'b1;
					if (!cmd.short_ok) begin
						st_d = ST_BROKEN;
					end else begin
						n_wr  = {1'b0, cmd.short_len};
						cnt_d = CW'(cmd.short_len);
						st_d  = ST_COMPLETE;
					end
				end else begin
					hb_d = 1'b1;
					if (cmd.spawn_always || (cmd.spawn_if_held && cnt_q != '0)) begin
						spawn = 1'b1;
					end else if (sum > (CW + 1)'(BUFFER_BYTES)) begin
						// only the bytes that still fit are kept
						n_wr  = room[2:0];
						cnt_d = CW'(BUFFER_BYTES);
						st_d  = ST_BROKEN;
					end else begin
						n_wr  = cmd.sysex_len;
						cnt_d = sum[CW-1:0];
						if (cmd.eox_found) begin
							st_d = ST_COMPLETE;
						end
					end
				end
			end
			OP_START: begin
				st_d  = ST_INCOMPLETE;
				cnt_d = '0;
				hb_d  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// byte address a lands in bank a[1:0], so a word's lanes never collide
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0]    bank_mem [0:D-1];
		logic [1:0]    lane;
		logic [CW-1:0] wr_addr;
		logic          we;

		assign lane    = 2'(b) - cnt_q[1:0];
		assign wr_addr = cnt_q + CW'(lane);
		assign we      = q_pop && ({1'b0, lane} < n_wr);

		always_ff @(posedge clk) begin
			if (we) begin
				bank_mem[wr_addr[2 +: RW]] <= cmd.msg[lane];
			end
			if (q_pop) begin
				rd_row_q[b] <= bank_mem[rd_row];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INCOMPLETE;
			cnt_q       <= '0;
			hb_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				st_q  <= st_d;
				cnt_q <= cnt_d;
				hb_q  <= hb_d;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ev_state_q <= st_d;
			ev_size_q  <= 11'(cnt_d);
			spawned_q  <= spawn;
			sp_state_q <= spawn ? cmd.fresh_state : ST_INCOMPLETE;
			sp_size_q  <= spawn ? cmd.fresh_size : 3'd0;
			hit_q      <= rd_hit;
			lane_q     <= cmd.read_index[1:0];
		end
	end

	assign read_byte     = hit_q ? rd_row_q[lane_q] : 8'd0;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = spawned_q;
	assign m_axis_tdata  = {6'd0, read_byte, sp_size_q, sp_state_q, ev_size_q, ev_state_q};

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && cmd.op == OP_START |=> cnt_q == '0 && !hb_q && st_q == ST_INCOMPLETE)
		else $error("start request did not empty the event");

	a_spawn_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && spawn |=> $stable(cnt_q))
		else $error("diverted word changed the held event size");

	a_no_word_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		!hb_q |-> cnt_q == '0)
		else $error("bytes held before any word was taken");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && cmd.op != OP_START |=> cnt_q >= $past(cnt_q))
		else $error("event size shrank without a start request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> cnt_q <= CW'(BUFFER_BYTES))
		else $error("event size beyond the byte store");

endmodule

[src/midi_packed_word_event_assembler.sv]
// midi_packed_word_event_assembler: top level, front classifier, request queue, back end
// depends on mpwea_pkg, mpwea_front, mpwea_queue, mpwea_back
//
// Usage:
//   s_axis carries one request per transfer: tuser holds the operation
//   (append word, start event, read byte, no-op), tdata the packed word
//   and the read index. m_axis returns exactly one result per request,
//   in order: held event state and size, the diverted event's state and
//   size (tuser flags a diversion) and the byte read.
//   A request accepted on s_axis is classified and written into the
//   queue, taken from it by the back end and registered in the result
//   register. The back end updates the event state and writes up to four
//   bytes into four byte banks in the same cycle, so one request per cycle
//   is sustained while m_axis accepts results.
//   When m_axis stalls, the result register holds, the two-entry queue
//   fills and s_axis_tready drops once it is full.
//   Reset empties the queue and the result register and leaves an empty,
//   incomplete event; the byte store is not cleared, reads at or past the
//   event size return zero.
module midi_packed_word_event_assembler #(
	parameter int BUFFER_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // message[31:0], read_index[41:32], zero
	input  logic [1:0]  s_axis_tuser,   // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // event_state[1:0], event_size[12:2],
	                                    // spawned_state[14:13], spawned_size[17:15],
	                                    // read_byte[25:18], zero
	output logic [0:0]  m_axis_tuser    // spawned
);
	import mpwea_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic full;
	logic pop;
	logic head_valid;

	mpwea_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (full),
		.q_push        (push),
		.q_cmd         (push_cmd)
	);

	mpwea_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.valid    (head_valid),
		.head     (head_cmd)
	);

	mpwea_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (head_valid),
		.cmd           (head_cmd),
		.q_pop         (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule
